>>> sv/lcs_pkg.sv
package lcs_pkg;

  typedef enum logic [1:0] {
    OP_GET   = 2'd0,
    OP_PUT   = 2'd1,
    OP_CLEAR = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_HIT      = 3'd0,
    ST_MISS     = 3'd1,
    ST_STALE    = 3'd2,
    ST_INSERTED = 3'd3,
    ST_UPDATED  = 3'd4,
    ST_EVICTED  = 3'd5,
    ST_REJECTED = 3'd6,
    ST_CLEARED  = 3'd7
  } status_e;

  typedef enum logic [1:0] {
    FSM_IDLE   = 2'd0,
    FSM_MATCH  = 2'd1,
    FSM_UPDATE = 2'd2,
    FSM_RESULT = 2'd3
  } fsm_e;

  localparam logic CFG_MAX_ENTRIES = 1'b0;
  localparam logic CFG_MAX_SIZE    = 1'b1;

  localparam logic [4:0]  MAX_ENTRIES_RST = 5'd16;
  localparam logic [31:0] MAX_SIZE_RST    = 32'd1048576;

  // per-cell update command
  typedef enum logic [2:0] {
    CMD_NONE   = 3'd0,
    CMD_TOUCH  = 3'd1,
    CMD_DROP   = 3'd2,
    CMD_INSERT = 3'd3,
    CMD_CLEAR  = 3'd4,
    CMD_UPDATE = 3'd5
  } cmd_e;

endpackage

>>> sv/lcs_cell.sv
// one cache entry; a running free-slot marker passes down the chain
module lcs_cell #(
  parameter int KEY_BITS  = 64,
  parameter int RANK_BITS = 4
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  lcs_pkg::cmd_e        cmd_i,
  input  logic                 sel_i,
  input  logic [RANK_BITS-1:0] ref_rank_i,
  input  logic [KEY_BITS-1:0]  key_i,
  input  logic [31:0]          time_i,
  input  logic [31:0]          content_i,
  input  logic                 free_found_i,
  output logic                 free_found_o,
  output logic                 valid_o,
  output logic                 match_o,
  output logic [RANK_BITS-1:0] rank_o,
  output logic [31:0]          time_o,
  output logic [31:0]          content_o
);
  import lcs_pkg::*;

  logic                 valid_q, valid_d;
  logic [KEY_BITS-1:0]  key_q;
  logic [31:0]          time_q, content_q;
  logic [RANK_BITS-1:0] rank_q, rank_d;
  logic                 take;

  // first free cell in chain order takes an insert
  assign take         = !valid_q && !free_found_i;
  assign free_found_o = free_found_i || !valid_q;

  always_comb begin
    valid_d = valid_q;
    rank_d  = rank_q;
    case (cmd_i)
      CMD_TOUCH, CMD_UPDATE: begin
        if (sel_i) rank_d = '0;
        else if (valid_q && rank_q < ref_rank_i) rank_d = rank_q + 1'b1;
      end
      CMD_DROP: begin
        if (sel_i) valid_d = 1'b0;
        else if (valid_q && rank_q > ref_rank_i) rank_d = rank_q - 1'b1;
      end
      CMD_INSERT: begin
        if (take) begin
          valid_d = 1'b1;
          rank_d  = '0;
        end else if (valid_q) rank_d = rank_q + 1'b1;
      end
      CMD_CLEAR: valid_d = 1'b0;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rank_q <= rank_d;
    if ((cmd_i == CMD_INSERT && take) || (cmd_i == CMD_UPDATE && sel_i)) begin
      content_q <= content_i;
      time_q    <= time_i;
    end
    if (cmd_i == CMD_INSERT && take) key_q <= key_i;
  end

  assign valid_o   = valid_q;
  assign match_o   = valid_q && key_q == key_i;
  assign rank_o    = rank_q;
  assign time_o    = time_q;
  assign content_o = content_q;
endmodule

>>> sv/lru_cache_with_staleness_core.sv
// Fully associative LRU cache built as a chain of DEPTH entry cells with
// per-entry recency ranks. A transaction passes through the parallel key
// compare with a registered match vector, then a rank/valid update across
// all cells, then holds in the result register until it is taken. A new
// transaction is accepted once the result is taken (or in the same cycle it is
// taken). An insert when occupancy has reached the entry limit first drops the
// least recent entry in an extra pass through the update state. Clear empties
// all cells at once.
module lru_cache_with_staleness_core #(
  parameter int DEPTH    = 16,
  parameter int KEY_BITS = 64
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic                    cfg_index_i,
  input  logic [31:0]             cfg_data_i,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic [1:0]              operation_i,
  input  logic [63:0]             key_i,
  input  logic [31:0]             mod_time_i,
  input  logic [31:0]             content_handle_i,
  input  logic [31:0]             item_size_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic [2:0]              status_o,
  output logic [31:0]             hit_content_o,
  output logic [$clog2(DEPTH+1)-1:0] occupancy_o
);
  import lcs_pkg::*;

  localparam int RB = $clog2(DEPTH);
  localparam int CB = $clog2(DEPTH+1);

  fsm_e state_q, state_d;

  logic [4:0]  max_entries_q;
  logic [31:0] max_size_q;

  logic [1:0]          op_q;
  logic [KEY_BITS-1:0] key_q;
  logic [31:0]         time_q, content_q, size_q;
  logic [CB-1:0]       count_q, count_d;
  logic                evict_q, evict_d;

  logic [DEPTH-1:0]    valid_w, match_w, sel_w;
  logic [DEPTH:0]      free_w;
  logic [RB-1:0]       rank_w [DEPTH];
  logic [31:0]         etime_w [DEPTH], econt_w [DEPTH];
  logic [DEPTH-1:0]    match_q;
  logic [31:0]         mtime_q, mcont_q;
  logic [RB-1:0]       mrank_q;
  logic [DEPTH-1:0]    lru_q;
  logic [31:0]         mtime_w, mcont_w;
  logic [RB-1:0]       mrank_w;
  logic [DEPTH-1:0]    lru_w;

  cmd_e          cmd;
  logic [RB-1:0] ref_rank;

  logic [2:0]    status_q, status_d;
  logic [31:0]   hit_q, hit_d;
  logic [CB-1:0] limit;

  assign limit = (max_entries_q == 5'd0) ? CB'(1) :
                 ({27'd0, max_entries_q} > DEPTH) ? CB'(DEPTH) : CB'(max_entries_q);

  assign free_w[0] = 1'b0;

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    lcs_cell #(.KEY_BITS(KEY_BITS), .RANK_BITS(RB)) u_cell (
      .clk_i, .rst_ni,
      .cmd_i(cmd), .sel_i(sel_w[g]), .ref_rank_i(ref_rank),
      .key_i(key_q), .time_i(time_q), .content_i(content_q),
      .free_found_i(free_w[g]), .free_found_o(free_w[g+1]),
      .valid_o(valid_w[g]), .match_o(match_w[g]), .rank_o(rank_w[g]),
      .time_o(etime_w[g]), .content_o(econt_w[g])
    );
  end

  // matching entry fields and lru position, match is one-hot
  always_comb begin
    mtime_w = '0;
    mcont_w = '0;
    mrank_w = '0;
    for (int i = 0; i < DEPTH; i++) begin
      lru_w[i] = valid_w[i] && (rank_w[i] == RB'(count_q - 1'b1));
      if (match_w[i]) begin
        mtime_w = etime_w[i];
        mcont_w = econt_w[i];
        mrank_w = rank_w[i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == FSM_MATCH) begin
      match_q <= match_w;
      mtime_q <= mtime_w;
      mcont_q <= mcont_w;
      mrank_q <= mrank_w;
      lru_q   <= lru_w;
    end else if (state_q == FSM_UPDATE && evict_q) begin
      lru_q <= '0;
    end
  end

  logic any_match, hit_ok, do_put;
  assign any_match = |match_q;
  assign hit_ok    = (time_q == 32'd0) || (mtime_q == time_q);
  assign do_put    = size_q <= max_size_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      FSM_IDLE:   if (in_valid_i) state_d = FSM_MATCH;
      FSM_MATCH:  state_d = FSM_UPDATE;
      FSM_UPDATE: if (!evict_d) state_d = FSM_RESULT;
      FSM_RESULT: if (out_ready_i) state_d = in_valid_i ? FSM_MATCH : FSM_IDLE;
      default:    state_d = FSM_IDLE;
    endcase
  end

  always_comb begin
    cmd      = CMD_NONE;
    sel_w    = match_q;
    ref_rank = mrank_q;
    status_d = status_q;
    hit_d    = hit_q;
    count_d  = count_q;
    evict_d  = 1'b0;
    if (state_q == FSM_UPDATE) begin
      hit_d = '0;
      unique case (op_e'(op_q))
        OP_GET: begin
          if (!any_match) status_d = ST_MISS;
          else if (hit_ok) begin
            cmd = CMD_TOUCH; status_d = ST_HIT; hit_d = mcont_q;
          end else begin
            cmd = CMD_DROP; status_d = ST_STALE; count_d = count_q - 1'b1;
          end
        end
        OP_PUT: begin
          if (!do_put) status_d = ST_REJECTED;
          else if (any_match) begin
            cmd = CMD_UPDATE; status_d = ST_UPDATED;
          end else if (!evict_q && count_q >= limit && count_q != '0) begin
            // drop lru first, insert on the next cycle
            cmd = CMD_DROP; sel_w = lru_q; ref_rank = RB'(count_q - 1'b1);
            count_d = count_q - 1'b1; evict_d = 1'b1; status_d = ST_EVICTED;
          end else begin
            cmd = CMD_INSERT;
            if (!evict_q) status_d = ST_INSERTED;
            if (!free_w[DEPTH]) count_d = count_q;
            else count_d = count_q + 1'b1;
          end
        end
        OP_CLEAR: begin
          cmd = CMD_CLEAR; status_d = ST_CLEARED; count_d = '0;
        end
        default: status_d = ST_MISS;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= FSM_IDLE;
      max_entries_q <= MAX_ENTRIES_RST;
      max_size_q    <= MAX_SIZE_RST;
      count_q       <= '0;
      evict_q       <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      evict_q <= evict_d;
      if (cfg_we_i) begin
        if (cfg_index_i == CFG_MAX_ENTRIES) max_entries_q <= cfg_data_i[4:0];
        else max_size_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    status_q <= status_d;
    hit_q    <= hit_d;
    if (in_valid_i && in_ready_o) begin
      op_q      <= operation_i;
      key_q     <= key_i[KEY_BITS-1:0];
      time_q    <= mod_time_i;
      content_q <= content_handle_i;
      size_q    <= item_size_i;
    end
  end

  assign in_ready_o    = (state_q == FSM_IDLE) || (state_q == FSM_RESULT && out_ready_i);
  assign out_valid_o   = state_q == FSM_RESULT;
  assign status_o      = status_q;
  assign hit_content_o = hit_q;
  assign occupancy_o   = count_q;
endmodule

>>> sv/lcs_checker.sv
module lcs_checker #(
  parameter int DEPTH = 16
) (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_valid_i,
  input logic                       in_ready_o,
  input logic                       out_valid_o,
  input logic                       out_ready_i,
  input logic [2:0]                 status_o,
  input logic [31:0]                hit_content_o,
  input logic [$clog2(DEPTH+1)-1:0] occupancy_o
);
  import lcs_pkg::*;

  a_occ_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> occupancy_o <= DEPTH) else $error("occupancy out of range");

  a_cleared_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == ST_CLEARED |-> occupancy_o == '0)
    else $error("clear left entries");

  a_content_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != ST_HIT |-> hit_content_o == '0)
    else $error("content on non-hit");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(status_o))
    else $error("result dropped");

  // an accepted transaction passes the compare state before any result shows
  a_accept_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !out_valid_o)
    else $error("result too early after accept");
endmodule

bind lru_cache_with_staleness_core lcs_checker #(.DEPTH(DEPTH)) u_lcs_checker (.*);

>>> test/testbench.sv
module testbench;
  import lcs_pkg::*;

  localparam int DEPTH = 16;
  localparam int LIMIT = 400000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic        cfg_index_i = 1'b0;
  logic [31:0] cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [1:0]  operation_i = '0;
  logic [63:0] key_i = '0;
  logic [31:0] mod_time_i = '0;
  logic [31:0] content_handle_i = '0;
  logic [31:0] item_size_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [2:0]  status_o;
  logic [31:0] hit_content_o;
  logic [4:0]  occupancy_o;

  lru_cache_with_staleness_core #(.DEPTH(DEPTH), .KEY_BITS(64)) uut (.*);

  typedef struct packed {
    status_e     status;
    logic [31:0] content;
    logic [4:0]  occ;
  } cache_rsp_t;

  class cache_scoreboard;
    logic [4:0]  lim_reg;
    logic [31:0] size_reg;
    bit          vld  [DEPTH];
    logic [63:0] keys [DEPTH];
    logic [31:0] cont [DEPTH];
    logic [31:0] mtim [DEPTH];
    int          rank [DEPTH];
    int          count;
    cache_rsp_t  pending[$];
    int          errors;
    int          n_status[8];

    function new();
      lim_reg = MAX_ENTRIES_RST;
      size_reg = MAX_SIZE_RST;
      count = 0;
      errors = 0;
      foreach (vld[i]) vld[i] = 0;
    endfunction

    function int find(logic [63:0] k);
      for (int i = 0; i < DEPTH; i++) if (vld[i] && keys[i] == k) return i;
      return DEPTH;
    endfunction

    function void touch(int idx);
      for (int i = 0; i < DEPTH; i++) if (vld[i] && rank[i] < rank[idx]) rank[i]++;
      rank[idx] = 0;
    endfunction

    function void drop(int idx);
      vld[idx] = 0;
      for (int i = 0; i < DEPTH; i++) if (vld[i] && rank[i] > rank[idx]) rank[i]--;
      if (count > 0) count--;
    endfunction

    function void note_item(op_e op, logic [63:0] k, logic [31:0] t,
                            logic [31:0] c, logic [31:0] sz);
      cache_rsp_t r;
      int idx, lim, v;
      r.status = ST_MISS;
      r.content = '0;
      lim = (lim_reg == 0) ? 1 : (lim_reg > DEPTH ? DEPTH : int'(lim_reg));
      case (op)
        OP_GET: begin
          idx = find(k);
          if (idx < DEPTH) begin
            if (t == 0 || mtim[idx] == t) begin
              touch(idx);
              r.content = cont[idx];
              r.status = ST_HIT;
            end else begin
              drop(idx);
              r.status = ST_STALE;
            end
          end
        end
        OP_PUT: begin
          if (sz > size_reg) r.status = ST_REJECTED;
          else begin
            idx = find(k);
            if (idx < DEPTH) begin
              cont[idx] = c;
              mtim[idx] = t;
              touch(idx);
              r.status = ST_UPDATED;
            end else begin
              r.status = ST_INSERTED;
              if (count >= lim && count > 0) begin
                v = DEPTH;
                for (int i = DEPTH - 1; i >= 0; i--)
                  if (vld[i] && rank[i] == count - 1) v = i;
                if (v < DEPTH) drop(v);
                r.status = ST_EVICTED;
              end
              idx = DEPTH;
              for (int i = DEPTH - 1; i >= 0; i--) if (!vld[i]) idx = i;
              if (idx < DEPTH) begin
                for (int i = 0; i < DEPTH; i++) if (vld[i]) rank[i]++;
                vld[idx] = 1;
                keys[idx] = k;
                cont[idx] = c;
                mtim[idx] = t;
                rank[idx] = 0;
                count++;
              end
            end
          end
        end
        OP_CLEAR: begin
          foreach (vld[i]) vld[i] = 0;
          count = 0;
          r.status = ST_CLEARED;
        end
        default: ;
      endcase
      r.occ = count[4:0];
      n_status[r.status]++;
      pending.push_back(r);
    endfunction

    function void check_result(logic [2:0] st, logic [31:0] hc, logic [4:0] occ);
      cache_rsp_t e;
      if (pending.size() == 0) begin
        $error("unexpected result status=%0d", st);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (st !== e.status) begin
        $error("status: expected %0d, got %0d", e.status, st);
        errors++;
      end
      if (hc !== e.content) begin
        $error("hit_content: expected %h, got %h", e.content, hc);
        errors++;
      end
      if (occ !== e.occ) begin
        $error("occupancy: expected %0d, got %0d", e.occ, occ);
        errors++;
      end
    endfunction
  endclass

  cache_scoreboard sb;
  bit   idle_on = 1'b1;
  int   cycles = 0;
  logic [63:0] key_pool[8];

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("testbench: done, errors");
      $finish;
    end
  end

  // result side: random stall bursts, checks every accepted transaction
  initial begin
    int gap;
    @(posedge rst_ni);
    forever begin
      if (idle_on && $urandom_range(0, 3) == 0) begin
        gap = $urandom_range(1, 4);
        out_ready_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      @(posedge clk_i);
      if (out_valid_o && out_ready_i) sb.check_result(status_o, hit_content_o, occupancy_o);
    end
  end

  task automatic write_reg(logic idx, logic [31:0] val);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_MAX_ENTRIES) sb.lim_reg = val[4:0];
    else sb.size_reg = val;
    @(posedge clk_i);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  // valid stays high after acceptance until the next item, a gap or a drain
  task automatic send(op_e op, logic [63:0] k, logic [31:0] t,
                      logic [31:0] c, logic [31:0] sz);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    operation_i <= op;
    key_i <= k;
    mod_time_i <= t;
    content_handle_i <= c;
    item_size_i <= sz;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sb.note_item(op, k, t, c, sz);
  endtask

  task automatic random_item();
    logic [63:0] k;
    logic [31:0] t, sz;
    int p;
    k = $urandom_range(0, 9) == 0 ? {$urandom, $urandom} : key_pool[$urandom_range(0, 7)];
    t = $urandom_range(0, 2) == 0 ? 32'd0 : $urandom_range(1, 3);
    if ($urandom_range(0, 15) == 0) t = $urandom;
    sz = $urandom_range(0, 5) == 0 ? $urandom : $urandom_range(0, 4096);
    p = $urandom_range(0, 99);
    if (p < 45) send(OP_GET, k, t, 0, $urandom);
    else if (p < 93) send(OP_PUT, k, t, $urandom, sz);
    else if (p < 97) send(OP_CLEAR, k, $urandom, $urandom, $urandom);
    else send(OP_NONE, k, t, $urandom, $urandom);
  endtask

  initial begin
    sb = new();
    foreach (key_pool[i]) key_pool[i] = {$urandom, $urandom};
    key_pool[0] = '0;
    key_pool[1] = '1;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty lookup, field extremes, stale removal, oversize reject, clear, unused op, overfill
    send(OP_GET, '0, '0, '0, '0);
    send(OP_PUT, '1, '1, '1, 32'd1048576);
    send(OP_PUT, '0, 32'd5, 32'hA5A5A5A5, '0);
    send(OP_PUT, 64'h1, 32'd5, 32'h1, 32'd1048577);
    send(OP_GET, '1, '1, '0, '0);
    send(OP_GET, '0, '0, '0, '0);
    send(OP_GET, '1, 32'd7, '0, '0);
    send(OP_PUT, '0, 32'd6, 32'h5A5A5A5A, '1);
    send(OP_PUT, '0, 32'd6, 32'h5A5A5A5A, 32'd10);
    send(OP_NONE, '0, '1, '1, '1);
    send(OP_GET, '0, 32'd6, '0, '0);
    send(OP_CLEAR, '1, '1, '1, '1);
    for (int i = 0; i < 18; i++) send(OP_PUT, 64'(i) << 40, i, i, i);
    drain();

    // limit lowered below occupancy, then zero limit and extreme sizes
    write_reg(CFG_MAX_ENTRIES, 32'd3);
    write_reg(CFG_MAX_SIZE, '1);
    send(OP_PUT, 64'h77, 32'd1, 32'd2, '1);
    send(OP_GET, 64'h77, '0, '0, '0);
    drain();
    write_reg(CFG_MAX_ENTRIES, 32'd0);
    write_reg(CFG_MAX_SIZE, '0);
    send(OP_PUT, 64'h78, 32'd1, 32'd2, 32'd1);
    send(OP_PUT, 64'h78, 32'd1, 32'd2, 32'd0);
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin write_reg(CFG_MAX_ENTRIES, 32'd4); write_reg(CFG_MAX_SIZE, 32'd2048); end
        1: begin write_reg(CFG_MAX_ENTRIES, 32'd31); write_reg(CFG_MAX_SIZE, '1); end
        2: begin write_reg(CFG_MAX_ENTRIES, 32'd1); write_reg(CFG_MAX_SIZE, 32'd4096); end
        3: begin write_reg(CFG_MAX_ENTRIES, 32'd16); write_reg(CFG_MAX_SIZE, '0); end
        4: write_reg(CFG_MAX_ENTRIES, $urandom_range(2, 16));
        default: begin
          write_reg(CFG_MAX_ENTRIES, 32'd6);
          write_reg(CFG_MAX_SIZE, 32'd1048576);
          idle_on = 1'b0;
        end
      endcase
      for (int n = 0; n < 105; n++) random_item();
      drain();
    end

    $display("covered %0d hits, %0d stale, %0d evictions, %0d rejects, %0d clears",
             sb.n_status[ST_HIT], sb.n_status[ST_STALE], sb.n_status[ST_EVICTED],
             sb.n_status[ST_REJECTED], sb.n_status[ST_CLEARED]);
    if (sb.errors == 0) $display("testbench: done, clean");
    else $display("testbench: done, errors");
    $finish;
  end
endmodule
